@@ hdl/aes128_pkg.sv @@
// AES-128 package: S-box, GF(2^8) helpers, round transforms and payload types.
// Used by the round cell, the key schedule and the top level; depends on nothing.
package aes128_pkg;

   localparam int unsigned Rounds = 10;

   typedef struct packed {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      REG_KEY_HIGH = 2'd0,
      REG_KEY_LOW  = 2'd1
   } reg_index_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] s;
      case (a)
         8'h00: s = 8'h63; 8'h01: s = 8'h7c; 8'h02: s = 8'h77; 8'h03: s = 8'h7b;
         8'h04: s = 8'hf2; 8'h05: s = 8'h6b; 8'h06: s = 8'h6f; 8'h07: s = 8'hc5;
         8'h08: s = 8'h30; 8'h09: s = 8'h01; 8'h0a: s = 8'h67; 8'h0b: s = 8'h2b;
         8'h0c: s = 8'hfe; 8'h0d: s = 8'hd7; 8'h0e: s = 8'hab; 8'h0f: s = 8'h76;
         8'h10: s = 8'hca; 8'h11: s = 8'h82; 8'h12: s = 8'hc9; 8'h13: s = 8'h7d;
         8'h14: s = 8'hfa; 8'h15: s = 8'h59; 8'h16: s = 8'h47; 8'h17: s = 8'hf0;
         8'h18: s = 8'had; 8'h19: s = 8'hd4; 8'h1a: s = 8'ha2; 8'h1b: s = 8'haf;
         8'h1c: s = 8'h9c; 8'h1d: s = 8'ha4; 8'h1e: s = 8'h72; 8'h1f: s = 8'hc0;
         8'h20: s = 8'hb7; 8'h21: s = 8'hfd; 8'h22: s = 8'h93; 8'h23: s = 8'h26;
         8'h24: s = 8'h36; 8'h25: s = 8'h3f; 8'h26: s = 8'hf7; 8'h27: s = 8'hcc;
         8'h28: s = 8'h34; 8'h29: s = 8'ha5; 8'h2a: s = 8'he5; 8'h2b: s = 8'hf1;
         8'h2c: s = 8'h71; 8'h2d: s = 8'hd8; 8'h2e: s = 8'h31; 8'h2f: s = 8'h15;
         8'h30: s = 8'h04; 8'h31: s = 8'hc7; 8'h32: s = 8'h23; 8'h33: s = 8'hc3;
         8'h34: s = 8'h18; 8'h35: s = 8'h96; 8'h36: s = 8'h05; 8'h37: s = 8'h9a;
         8'h38: s = 8'h07; 8'h39: s = 8'h12; 8'h3a: s = 8'h80; 8'h3b: s = 8'he2;
         8'h3c: s = 8'heb; 8'h3d: s = 8'h27; 8'h3e: s = 8'hb2; 8'h3f: s = 8'h75;
         8'h40: s = 8'h09; 8'h41: s = 8'h83; 8'h42: s = 8'h2c; 8'h43: s = 8'h1a;
         8'h44: s = 8'h1b; 8'h45: s = 8'h6e; 8'h46: s = 8'h5a; 8'h47: s = 8'ha0;
         8'h48: s = 8'h52; 8'h49: s = 8'h3b; 8'h4a: s = 8'hd6; 8'h4b: s = 8'hb3;
         8'h4c: s = 8'h29; 8'h4d: s = 8'he3; 8'h4e: s = 8'h2f; 8'h4f: s = 8'h84;
         8'h50: s = 8'h53; 8'h51: s = 8'hd1; 8'h52: s = 8'h00; 8'h53: s = 8'hed;
         8'h54: s = 8'h20; 8'h55: s = 8'hfc; 8'h56: s = 8'hb1; 8'h57: s = 8'h5b;
         8'h58: s = 8'h6a; 8'h59: s = 8'hcb; 8'h5a: s = 8'hbe; 8'h5b: s = 8'h39;
         8'h5c: s = 8'h4a; 8'h5d: s = 8'h4c; 8'h5e: s = 8'h58; 8'h5f: s = 8'hcf;
         8'h60: s = 8'hd0; 8'h61: s = 8'hef; 8'h62: s = 8'haa; 8'h63: s = 8'hfb;
         8'h64: s = 8'h43; 8'h65: s = 8'h4d; 8'h66: s = 8'h33; 8'h67: s = 8'h85;
         8'h68: s = 8'h45; 8'h69: s = 8'hf9; 8'h6a: s = 8'h02; 8'h6b: s = 8'h7f;
         8'h6c: s = 8'h50; 8'h6d: s = 8'h3c; 8'h6e: s = 8'h9f; 8'h6f: s = 8'ha8;
         8'h70: s = 8'h51; 8'h71: s = 8'ha3; 8'h72: s = 8'h40; 8'h73: s = 8'h8f;
         8'h74: s = 8'h92; 8'h75: s = 8'h9d; 8'h76: s = 8'h38; 8'h77: s = 8'hf5;
         8'h78: s = 8'hbc; 8'h79: s = 8'hb6; 8'h7a: s = 8'hda; 8'h7b: s = 8'h21;
         8'h7c: s = 8'h10; 8'h7d: s = 8'hff; 8'h7e: s = 8'hf3; 8'h7f: s = 8'hd2;
         8'h80: s = 8'hcd; 8'h81: s = 8'h0c; 8'h82: s = 8'h13; 8'h83: s = 8'hec;
         8'h84: s = 8'h5f; 8'h85: s = 8'h97; 8'h86: s = 8'h44; 8'h87: s = 8'h17;
         8'h88: s = 8'hc4; 8'h89: s = 8'ha7; 8'h8a: s = 8'h7e; 8'h8b: s = 8'h3d;
         8'h8c: s = 8'h64; 8'h8d: s = 8'h5d; 8'h8e: s = 8'h19; 8'h8f: s = 8'h73;
         8'h90: s = 8'h60; 8'h91: s = 8'h81; 8'h92: s = 8'h4f; 8'h93: s = 8'hdc;
         8'h94: s = 8'h22; 8'h95: s = 8'h2a; 8'h96: s = 8'h90; 8'h97: s = 8'h88;
         8'h98: s = 8'h46; 8'h99: s = 8'hee; 8'h9a: s = 8'hb8; 8'h9b: s = 8'h14;
         8'h9c: s = 8'hde; 8'h9d: s = 8'h5e; 8'h9e: s = 8'h0b; 8'h9f: s = 8'hdb;
         8'ha0: s = 8'he0; 8'ha1: s = 8'h32; 8'ha2: s = 8'h3a; 8'ha3: s = 8'h0a;
         8'ha4: s = 8'h49; 8'ha5: s = 8'h06; 8'ha6: s = 8'h24; 8'ha7: s = 8'h5c;
         8'ha8: s = 8'hc2; 8'ha9: s = 8'hd3; 8'haa: s = 8'hac; 8'hab: s = 8'h62;
         8'hac: s = 8'h91; 8'had: s = 8'h95; 8'hae: s = 8'he4; 8'haf: s = 8'h79;
         8'hb0: s = 8'he7; 8'hb1: s = 8'hc8; 8'hb2: s = 8'h37; 8'hb3: s = 8'h6d;
         8'hb4: s = 8'h8d; 8'hb5: s = 8'hd5; 8'hb6: s = 8'h4e; 8'hb7: s = 8'ha9;
         8'hb8: s = 8'h6c; 8'hb9: s = 8'h56; 8'hba: s = 8'hf4; 8'hbb: s = 8'hea;
         8'hbc: s = 8'h65; 8'hbd: s = 8'h7a; 8'hbe: s = 8'hae; 8'hbf: s = 8'h08;
         8'hc0: s = 8'hba; 8'hc1: s = 8'h78; 8'hc2: s = 8'h25; 8'hc3: s = 8'h2e;
         8'hc4: s = 8'h1c; 8'hc5: s = 8'ha6; 8'hc6: s = 8'hb4; 8'hc7: s = 8'hc6;
         8'hc8: s = 8'he8; 8'hc9: s = 8'hdd; 8'hca: s = 8'h74; 8'hcb: s = 8'h1f;
         8'hcc: s = 8'h4b; 8'hcd: s = 8'hbd; 8'hce: s = 8'h8b; 8'hcf: s = 8'h8a;
         8'hd0: s = 8'h70; 8'hd1: s = 8'h3e; 8'hd2: s = 8'hb5; 8'hd3: s = 8'h66;
         8'hd4: s = 8'h48; 8'hd5: s = 8'h03; 8'hd6: s = 8'hf6; 8'hd7: s = 8'h0e;
         8'hd8: s = 8'h61; 8'hd9: s = 8'h35; 8'hda: s = 8'h57; 8'hdb: s = 8'hb9;
         8'hdc: s = 8'h86; 8'hdd: s = 8'hc1; 8'hde: s = 8'h1d; 8'hdf: s = 8'h9e;
         8'he0: s = 8'he1; 8'he1: s = 8'hf8; 8'he2: s = 8'h98; 8'he3: s = 8'h11;
         8'he4: s = 8'h69; 8'he5: s = 8'hd9; 8'he6: s = 8'h8e; 8'he7: s = 8'h94;
         8'he8: s = 8'h9b; 8'he9: s = 8'h1e; 8'hea: s = 8'h87; 8'heb: s = 8'he9;
         8'hec: s = 8'hce; 8'hed: s = 8'h55; 8'hee: s = 8'h28; 8'hef: s = 8'hdf;
         8'hf0: s = 8'h8c; 8'hf1: s = 8'ha1; 8'hf2: s = 8'h89; 8'hf3: s = 8'h0d;
         8'hf4: s = 8'hbf; 8'hf5: s = 8'he6; 8'hf6: s = 8'h42; 8'hf7: s = 8'h68;
         8'hf8: s = 8'h41; 8'hf9: s = 8'h99; 8'hfa: s = 8'h2d; 8'hfb: s = 8'h0f;
         8'hfc: s = 8'hb0; 8'hfd: s = 8'h54; 8'hfe: s = 8'hbb; 8'hff: s = 8'h16;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] round);
      logic [7:0] r;
      case (round)
         4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
         4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
         4'd9: r = 8'h1b; 4'd10: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte k of the block sits at bits [127-8k -: 8]; byte index = 4*column + row.
   function automatic logic [127:0] sub_shift(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] mix_cols(input logic [127:0] s);
      logic [127:0] t;
      logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127 - 32 * c -: 8];
         a1 = s[119 - 32 * c -: 8];
         a2 = s[111 - 32 * c -: 8];
         a3 = s[103 - 32 * c -: 8];
         d0 = gf_dbl(a0);
         d1 = gf_dbl(a1);
         d2 = gf_dbl(a2);
         d3 = gf_dbl(a3);
         t[127 - 32 * c -: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         t[119 - 32 * c -: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         t[111 - 32 * c -: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         t[103 - 32 * c -: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      return t;
   endfunction

   // One step of the key expansion: round key r-1 to round key r.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [3:0] round);
      logic [31:0] w0, w1, w2, w3, g;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      g = {sbox(w3[23:16]) ^ rcon(round), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ g;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

endpackage

@@ hdl/aes128_key_sched.sv @@
// AES-128 key schedule: the eleven round keys, computed from the cipher key.
// Depends on aes128_pkg. Each round key is registered after its expansion step.
module aes128_key_sched (
   input  logic           clock,
   input  logic [127:0]   cipher_key,
   output logic [127:0]   round_keys [0:aes128_pkg::Rounds]
);

   logic [127:0] rk_ff [1:aes128_pkg::Rounds];

   // After a key write, the new key ripples down the chain, one round key per register.
   always_ff @(posedge clock) begin
      rk_ff[1] <= aes128_pkg::next_key(cipher_key, 4'd1);
      for (int r = 2; r <= aes128_pkg::Rounds; r++) begin
         rk_ff[r] <= aes128_pkg::next_key(rk_ff[r - 1], 4'(r));
      end
   end

   always_comb begin
      round_keys[0] = cipher_key;
      for (int r = 1; r <= aes128_pkg::Rounds; r++) begin
         round_keys[r] = rk_ff[r];
      end
   end

endmodule

@@ hdl/aes128_round_cell.sv @@
// One AES round cell: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes128_pkg. The cell advances when its enable is high.
module aes128_round_cell #(
   parameter bit LastRound = 1'b0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           in_valid,
   input  logic [127:0]   in_state,
   input  logic [127:0]   round_key,
   output logic           out_valid,
   output logic [127:0]   out_state
);

   logic         valid_ff;
   logic [127:0] state_ff;
   logic [127:0] shifted;
   logic [127:0] state_in;

   always_comb begin
      shifted = aes128_pkg::sub_shift(in_state);
      state_in = (LastRound ? shifted : aes128_pkg::mix_cols(shifted)) ^ round_key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ hdl/aes128_block_encrypt.sv @@
// AES-128 encryption, top level: configuration port, key schedule, round chain.
// Depends on aes128_pkg, aes128_key_sched and aes128_round_cell.
//
// Usage:
//   Plaintext blocks enter on the req_ channel, ciphertext leaves on the rsp_
//   channel; both are valid/ready transfers. The key is written through the
//   csr_ APB port: key_high at byte address 0, key_low at 8.
//   The datapath is a chain of eleven registered stages: the initial
//   AddRoundKey stage and ten round cells. A block passes through the stages
//   in order, and rsp_valid rises when it reaches the last round cell.
//   One block is taken every cycle while req_ready is high.
//   The whole chain advances together; when the output stage holds a block
//   that the receiver does not take, the chain freezes and req_ready drops.
//   Reset clears the key to zero and empties the chain.
//   The round keys sit in a registered chain that settles after a key write.
//   The user writes the key only while the block is idle; nothing enforces it.
module aes128_block_encrypt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  aes128_pkg::req_payload_type  req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output aes128_pkg::rsp_payload_type  rsp_payload,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [63:0]                  csr_pwdata,
   output logic [63:0]                  csr_prdata,
   output logic                         csr_pready
);

   localparam int unsigned Rounds = aes128_pkg::Rounds;

   logic [63:0]  key_high_ff;
   logic [63:0]  key_low_ff;
   logic         csr_write;
   logic [127:0] round_keys [0:Rounds];
   logic         advance;
   logic         v0_ff;
   logic [127:0] s0_ff;
   logic         cell_valid [0:Rounds];
   logic [127:0] cell_state [0:Rounds];

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3:3])
            1'(aes128_pkg::REG_KEY_HIGH): key_high_ff <= csr_pwdata;
            1'(aes128_pkg::REG_KEY_LOW):  key_low_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:3])
         1'(aes128_pkg::REG_KEY_HIGH): csr_prdata = key_high_ff;
         default:                      csr_prdata = key_low_ff;
      endcase
   end

   aes128_key_sched u_key_sched (
      .clock      (clock),
      .cipher_key ({key_high_ff, key_low_ff}),
      .round_keys (round_keys)
   );

   // The chain moves whenever the last stage is empty or its block is taken.
   assign advance   = !cell_valid[Rounds] || rsp_ready;
   assign req_ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_ff <= {req_payload.plain_high, req_payload.plain_low} ^ round_keys[0];
      end
   end

   assign cell_valid[0] = v0_ff;
   assign cell_state[0] = s0_ff;

   for (genvar r = 1; r <= Rounds; r++) begin : g_round
      aes128_round_cell #(
         .LastRound (r == Rounds)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cell_valid[r - 1]),
         .in_state  (cell_state[r - 1]),
         .round_key (round_keys[r]),
         .out_valid (cell_valid[r]),
         .out_state (cell_state[r])
      );
   end

   assign rsp_valid = cell_valid[Rounds];
   assign rsp_payload.cipher_high = cell_state[Rounds][127:64];
   assign rsp_payload.cipher_low  = cell_state[Rounds][63:0];

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with an empty output stage");

   a_transfer_arrives: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cell_valid[0])
      else $error("accepted block lost at the first stage");

endmodule
